### rtl/x86enc_pkg.sv
// Shared types, opcode constants and NOP table for the x86-64 instruction encoder.
package x86enc_pkg;

  localparam int ALIGN_BYTES_DEF = 8;
  localparam int PHASE_W         = 3;
  localparam int MAX_BYTES       = 8;
  localparam int CNT_W           = 4;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [3:0] {
    KIND_MOV_LD = 4'd0,
    KIND_MOV_ST = 4'd1,
    KIND_ADD_LD = 4'd2,
    KIND_ADD_ST = 4'd3,
    KIND_XOR_LD = 4'd4,
    KIND_XOR_ST = 4'd5,
    KIND_INC    = 4'd6,
    KIND_NOP    = 4'd7,
    KIND_ALIGN  = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    MODE_DIRECT  = 4'd0,
    MODE_IND     = 4'd1,
    MODE_D8      = 4'd2,
    MODE_D32     = 4'd3,
    MODE_RIP     = 4'd4,
    MODE_ABS     = 4'd5,
    MODE_IDX     = 4'd6,
    MODE_IDX_D8  = 4'd7,
    MODE_IDX_D32 = 4'd8
  } mode_t;

  localparam logic [7:0] REX_W    = 8'h48;
  localparam logic [7:0] OP_MOV_LD = 8'h8B;
  localparam logic [7:0] OP_MOV_ST = 8'h89;
  localparam logic [7:0] OP_ADD_LD = 8'h03;
  localparam logic [7:0] OP_ADD_ST = 8'h01;
  localparam logic [7:0] OP_XOR_LD = 8'h33;
  localparam logic [7:0] OP_XOR_ST = 8'h31;
  localparam logic [7:0] OP_INC    = 8'hFF;
  localparam logic [7:0] OP_NOP    = 8'h90;
  localparam logic [7:0] OP_ESC    = 8'h0F;
  localparam logic [7:0] OP_NOPL   = 8'h1F;
  localparam logic [7:0] OP_OPSIZE = 8'h66;

  // byte 0 is emitted first
  typedef logic [MAX_BYTES-1:0][7:0] x86enc_bytes_t;

  typedef struct packed {
    x86enc_bytes_t     bytes;
    logic [CNT_W-1:0]  count;
  } x86enc_entry_t;

  function automatic logic [7:0] pack3(input logic [1:0] hi2, input logic [2:0] mid3,
                                       input logic [2:0] lo3);
    return {hi2, mid3, lo3};
  endfunction

  function automatic logic [7:0] opcode(input logic [3:0] kind);
    logic [7:0] op;
    unique case (kind)
      KIND_MOV_LD: op = OP_MOV_LD;
      KIND_MOV_ST: op = OP_MOV_ST;
      KIND_ADD_LD: op = OP_ADD_LD;
      KIND_ADD_ST: op = OP_ADD_ST;
      KIND_XOR_LD: op = OP_XOR_LD;
      KIND_XOR_ST: op = OP_XOR_ST;
      default:     op = OP_INC;
    endcase
    return op;
  endfunction

  // recommended multi-byte NOP of a given length, zero padded
  function automatic x86enc_bytes_t nop_bytes(input logic [2:0] len);
    x86enc_bytes_t b;
    b = '0;
    unique case (len)
      3'd1: b[0] = OP_NOP;
      3'd2: begin
        b[0] = OP_OPSIZE; b[1] = OP_NOP;
      end
      3'd3: begin
        b[0] = OP_ESC; b[1] = OP_NOPL;
      end
      3'd4: begin
        b[0] = OP_ESC; b[1] = OP_NOPL; b[2] = 8'h40;
      end
      3'd5: begin
        b[0] = OP_ESC; b[1] = OP_NOPL; b[2] = 8'h44;
      end
      3'd6: begin
        b[0] = OP_OPSIZE; b[1] = OP_ESC; b[2] = OP_NOPL; b[3] = 8'h44;
      end
      3'd7: begin
        b[0] = OP_ESC; b[1] = OP_NOPL; b[2] = 8'h80;
      end
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

### rtl/x86enc_if.sv
// Valid/ready channel interfaces for instruction requests and code bytes.
interface x86enc_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [3:0]         mode;
  logic [3:0]         reg_field;
  logic [3:0]         base_reg;
  logic [3:0]         index_reg;
  logic [1:0]         scale;
  logic signed [31:0] displacement;

  modport source (output valid, kind, mode, reg_field, base_reg, index_reg, scale,
                  displacement, input ready);
  modport sink   (input valid, kind, mode, reg_field, base_reg, index_reg, scale,
                  displacement, output ready);
endinterface

interface x86enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

### rtl/x86enc_front.sv
// Front end: decode a request into its code bytes and track the stream phase.
module x86enc_front #(
  parameter int ALIGN_BYTES = x86enc_pkg::ALIGN_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  x86enc_in_if.sink                 in_req,
  input  logic                      q_full,
  output logic                      q_push,
  output x86enc_pkg::x86enc_entry_t q_entry
);
  import x86enc_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [2:0]         pad;
  logic [3:0]         reg_code;
  logic               use_b, use_x, accept;
  logic [7:0]         rex, op;
  logic [31:0]        d;
  x86enc_bytes_t      bytes;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   sum;

  assign pad = (phase_r == '0) ? 3'd0 : 3'(4'(ALIGN_BYTES) - {1'b0, phase_r});

  always_comb begin
    reg_code = (in_req.kind == KIND_INC) ? 4'd0 : in_req.reg_field;
    use_b    = (in_req.mode != MODE_RIP) && (in_req.mode != MODE_ABS);
    use_x    = (in_req.mode >= MODE_IDX);
    rex      = REX_W | {5'b0, reg_code[3], use_x & in_req.index_reg[3],
                        use_b & in_req.base_reg[3]};
    op       = opcode(in_req.kind);
    d        = in_req.displacement;
    bytes    = '0;
    n        = '0;
    if (in_req.kind <= KIND_INC) begin
      bytes[0] = rex;
      bytes[1] = op;
      unique case (in_req.mode)
        MODE_DIRECT: begin
          bytes[2] = pack3(2'd3, reg_code[2:0], in_req.base_reg[2:0]);
          n = 4'd3;
        end
        MODE_IND: begin
          bytes[2] = pack3(2'd0, reg_code[2:0], in_req.base_reg[2:0]);
          n = 4'd3;
        end
        MODE_D8: begin
          bytes[2] = pack3(2'd1, reg_code[2:0], in_req.base_reg[2:0]);
          bytes[3] = d[7:0];
          n = 4'd4;
        end
        MODE_D32: begin
          bytes[2] = pack3(2'd2, reg_code[2:0], in_req.base_reg[2:0]);
          bytes[6:3] = d;
          n = 4'd7;
        end
        MODE_RIP: begin
          bytes[2] = pack3(2'd0, reg_code[2:0], 3'd5);
          bytes[6:3] = d;
          n = 4'd7;
        end
        MODE_ABS: begin
          bytes[2] = pack3(2'd0, reg_code[2:0], 3'd4);
          bytes[3] = pack3(2'd0, 3'd4, 3'd5);
          bytes[7:4] = d;
          n = 4'd8;
        end
        MODE_IDX: begin
          bytes[2] = pack3(2'd0, reg_code[2:0], 3'd4);
          bytes[3] = pack3(in_req.scale, in_req.index_reg[2:0], in_req.base_reg[2:0]);
          n = 4'd4;
        end
        MODE_IDX_D8: begin
          bytes[2] = pack3(2'd1, reg_code[2:0], 3'd4);
          bytes[3] = pack3(in_req.scale, in_req.index_reg[2:0], in_req.base_reg[2:0]);
          bytes[4] = d[7:0];
          n = 4'd5;
        end
        MODE_IDX_D32: begin
          bytes[2] = pack3(2'd2, reg_code[2:0], 3'd4);
          bytes[3] = pack3(in_req.scale, in_req.index_reg[2:0], in_req.base_reg[2:0]);
          bytes[7:4] = d;
          n = 4'd8;
        end
        default: begin
          bytes = '0;
          n     = '0;
        end
      endcase
    end else if (in_req.kind == KIND_NOP) begin
      bytes[0] = OP_NOP;
      n        = 4'd1;
    end else if (in_req.kind == KIND_ALIGN) begin
      bytes = nop_bytes(pad);
      n     = {1'b0, pad};
    end
  end

  assign in_req.ready  = !q_full;
  assign accept        = in_req.valid && in_req.ready;
  assign q_push        = accept && (n != '0);
  assign q_entry.bytes = bytes;
  assign q_entry.count = n;

  // fold the new position back below the boundary
  always_comb begin
    sum = {1'b0, phase_r} + n;
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (sum >= 4'(ALIGN_BYTES)) begin
        sum = sum - 4'(ALIGN_BYTES);
      end
    end
    phase_nxt = accept ? sum[PHASE_W-1:0] : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, phase_r} < 4'(ALIGN_BYTES))
    else $error("stream phase out of range");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full && q_entry.count <= 4'(MAX_BYTES))
    else $error("push into full queue or oversized entry");

  a_nop_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.kind == KIND_NOP |-> q_push && q_entry.count == 4'd1)
    else $error("nop request not queued as one byte");

endmodule

### rtl/x86enc_fifo.sv
// Short queue of decoded instructions between front and back ends.
module x86enc_fifo #(
  parameter int DEPTH = x86enc_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  x86enc_pkg::x86enc_entry_t wr_entry,
  input  logic                      pop,
  output x86enc_pkg::x86enc_entry_t rd_entry,
  output logic                      full,
  output logic                      not_empty
);
  import x86enc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  x86enc_entry_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count overflow");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && full |-> pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

### rtl/x86enc_back.sv
// Back end: shift one queued instruction out one code byte per cycle while out_rsp.ready is high.
module x86enc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  x86enc_pkg::x86enc_entry_t q_entry,
  output logic                      q_pop,
  x86enc_out_if.source              out_rsp
);
  import x86enc_pkg::*;

  logic             valid_r, valid_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  x86enc_bytes_t    bytes_r, bytes_nxt;
  logic             take, load;

  assign take  = valid_r && out_rsp.ready;
  assign load  = q_valid && (!valid_r || (take && last_r));
  assign q_pop = load;

  assign out_rsp.valid    = valid_r;
  assign out_rsp.out_byte = bytes_r[0];
  assign out_rsp.last     = last_r;

  always_comb begin
    valid_nxt = valid_r;
    last_nxt  = last_r;
    rem_nxt   = rem_r;
    bytes_nxt = bytes_r;
    if (load) begin
      valid_nxt = 1'b1;
      bytes_nxt = q_entry.bytes;
      rem_nxt   = q_entry.count;
      last_nxt  = (q_entry.count == 4'd1);
    end else if (take) begin
      if (last_r) begin
        valid_nxt = 1'b0;
      end else begin
        // advance to the next byte
        bytes_nxt = bytes_r >> 8;
        rem_nxt   = rem_r - 1'b1;
        last_nxt  = (rem_r == 4'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      rem_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
      rem_r   <= rem_nxt;
    end
    bytes_r <= bytes_nxt;
  end

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> rem_r != '0 && rem_r <= 4'(MAX_BYTES))
    else $error("byte count out of range while emitting");

  a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> last_r == (rem_r == 4'd1))
    else $error("last flag out of step with byte count");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r && rem_r == $past(q_entry.count))
    else $error("popped entry not presented");

endmodule

### rtl/x86_64_instruction_encoder_core.sv
// Top level of the x86-64 instruction encoder: front end, queue and byte emitter.
//
//   channel  | dir | handshake                    | payload
//   in_req   | in  | in_req.valid / in_req.ready  | kind, mode, reg_field, base_reg,
//            |     |                              | index_reg, scale, displacement
//   out_rsp  | out | out_rsp.valid / out_rsp.ready| out_byte, last
//
// An instruction leaves the byte port as its bytes (1 to 8), one byte per cycle
// while out_rsp.ready is high; that port sets the sustained rate. Requests that
// make no bytes are accepted at the input and produce nothing.
// A request is decoded in the cycle it is accepted and queued at that edge; its
// first byte then passes from the queue into the emitter's register when idle.
// The two-entry queue lets new requests enter while bytes drain; the input stalls
// while both entries are held.
// Reset is synchronous, active low, and clears the stream phase, the queue and the emitter.
module x86_64_instruction_encoder_core #(
  parameter int ALIGN_BYTES = x86enc_pkg::ALIGN_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  x86enc_in_if.sink     in_req,
  x86enc_out_if.source  out_rsp
);
  import x86enc_pkg::*;

  logic          q_push, q_pop, q_full, q_not_empty;
  x86enc_entry_t q_wr_entry, q_rd_entry;

  x86enc_front #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wr_entry)
  );

  x86enc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_entry  (q_wr_entry),
    .pop       (q_pop),
    .rd_entry  (q_rd_entry),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  x86enc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_entry (q_rd_entry),
    .q_pop   (q_pop),
    .out_rsp (out_rsp)
  );

endmodule
